/* hw/rtl/four_gamete_pair_scan_assert.svh */
// Assertion macros for the checker file of the pair scanner.
// No dependencies; include with the bare file name.
`ifndef FOUR_GAMETE_PAIR_SCAN_ASSERT_SVH
`define FOUR_GAMETE_PAIR_SCAN_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FGPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("four_gamete_pair_scan: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FGPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("four_gamete_pair_scan: next-cycle check failed");

`endif

/* hw/rtl/fgps_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the pair scanner.
// No dependencies.
package fgps_pkg;

  // Store geometry.
  localparam int MAX_ROWS  = 4096;
  localparam int ROW_WIDTH = 24;
  localparam int IDX_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = IDX_W + 1;

  // Port field widths.
  localparam int IN_ROW_W  = 24;
  localparam int OUT_ROW_W = 12;
  localparam int TOTAL_W   = 23;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [CNT_W-1:0]   ROWS_CAP  = CNT_W'(MAX_ROWS);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_FIND  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_MATCH  = 2'd2,
    ST_NOMORE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic other;
    logic advance_first;
    logic issue_read;
    logic emit_nomore;
    logic emit_match;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic second_end;
    logic match;
    logic out_busy;
  } stat_t;

endpackage

/* hw/rtl/four_gamete_pair_scan.sv */
// Top level of the four-gamete pair scanner.
// Depends on fgps_pkg, fgps_ctrl, fgps_dp and fgps_ram.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  action, row_bits
//   output   out_valid/out_stall  status, first_row, second_row, match_count
//
// Clear, load and the unused action code are done in the idle state.
// A find enters the scan; each tested pair takes a registered read of the row
// store, then the compare, which also reports a match; the read state also
// steps the lower row and reports when there are no more pairs.
// Reset is synchronous and needs no clearing pass: only rows below the fill
// count are ever read. A stalled result holds the block before its next result.
module four_gamete_pair_scan
  import fgps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic [IN_ROW_W-1:0]  row_bits,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [OUT_ROW_W-1:0] first_row,
  output logic [OUT_ROW_W-1:0] second_row,
  output logic [TOTAL_W-1:0]   match_count
);

  cmd_t  cmd;
  stat_t stat;

  // Request decode and scan sequencing.
  fgps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, cursor and result register.
  fgps_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .row_bits    (row_bits),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .first_row   (first_row),
    .second_row  (second_row),
    .match_count (match_count)
  );

endmodule

/* hw/rtl/fgps_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module fgps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* hw/rtl/fgps_ctrl.sv */
// Controller state machine of the pair scanner: decodes requests and sequences the scan.
// Depends on fgps_pkg.
module fgps_ctrl
  import fgps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state, state_next;
  action_t act;

  assign act = action_t'(action);

  // A request is taken only in idle and only when the result register can take its result.
  assign in_stall = (state != S_IDLE) || stat.out_busy;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          case (act)
            ACT_CLEAR: cmd.clear = 1'b1;
            ACT_LOAD:  cmd.load  = 1'b1;
            ACT_FIND:  state_next = S_READ;
            default:   cmd.other = 1'b1;
          endcase
        end
      end
      S_READ: begin
        if (stat.scan_done) begin
          if (!stat.out_busy) begin
            cmd.emit_nomore = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (stat.second_end) begin
          cmd.advance_first = 1'b1;
        end else begin
          cmd.issue_read = 1'b1;
          state_next     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.match) begin
          if (!stat.out_busy) begin
            cmd.emit_match = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          state_next = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/fgps_dp.sv */
// Datapath of the pair scanner: row store, scan cursor, match counter and result register.
// Depends on fgps_pkg and fgps_ram.
module fgps_dp
  import fgps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IN_ROW_W-1:0]  row_bits,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [OUT_ROW_W-1:0] first_row,
  output logic [OUT_ROW_W-1:0] second_row,
  output logic [TOTAL_W-1:0]   match_count
);

  logic [CNT_W-1:0]     row_count;
  logic [IDX_W-1:0]     scan_first;
  logic [CNT_W-1:0]     scan_second;
  logic [TOTAL_W-1:0]   found_total;
  logic [TOTAL_W-1:0]   found_total_next;
  logic [IDX_W-1:0]     pair_second;
  logic                 full;
  logic                 emit_any;
  logic [ROW_WIDTH-1:0] row_a;
  logic [ROW_WIDTH-1:0] row_b;

  assign full     = (row_count == ROWS_CAP);
  assign emit_any = cmd.clear | cmd.load | cmd.other | cmd.emit_nomore | cmd.emit_match;

  // Row store; both rows of a pair are read in the same cycle.
  fgps_ram #(
    .WIDTH (ROW_WIDTH),
    .DEPTH (MAX_ROWS)
  ) u_store (
    .clk     (clk),
    .we      (cmd.load && !full),
    .waddr   (row_count[IDX_W-1:0]),
    .wdata   (ROW_WIDTH'(row_bits)),
    .re      (cmd.issue_read),
    .raddr_a (scan_first),
    .raddr_b (scan_second[IDX_W-1:0]),
    .rdata_a (row_a),
    .rdata_b (row_b)
  );

  // Four-gamete test and cursor limits.
  always_comb begin
    stat.match      = (|(row_a & row_b)) && (|(row_a & ~row_b)) &&
                      (|(~row_a & row_b)) && (|(~row_a & ~row_b));
    stat.scan_done  = (CNT_W'(scan_first) + CNT_W'(1)) >= row_count;
    stat.second_end = scan_second >= row_count;
    stat.out_busy   = out_valid && out_stall;
  end

  // Saturating match count.
  assign found_total_next = (found_total == TOTAL_MAX) ? found_total
                                                       : found_total + TOTAL_W'(1);

  // Control registers: store fill, cursor, count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= '0;
      scan_first  <= '0;
      scan_second <= CNT_W'(1);
      found_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (emit_any) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        row_count   <= '0;
        scan_first  <= '0;
        scan_second <= CNT_W'(1);
        found_total <= '0;
      end
      if (cmd.load && !full) begin
        row_count <= row_count + CNT_W'(1);
      end
      if (cmd.advance_first) begin
        scan_first  <= scan_first + IDX_W'(1);
        scan_second <= CNT_W'(scan_first) + CNT_W'(2);
      end
      if (cmd.issue_read) begin
        scan_second <= scan_second + CNT_W'(1);
      end
      if (cmd.emit_match) begin
        found_total <= found_total_next;
      end
    end
  end

  // Pair index and result payload.
  always_ff @(posedge clk) begin
    if (cmd.issue_read) begin
      pair_second <= scan_second[IDX_W-1:0];
    end
    if (cmd.clear) begin
      status      <= ST_OK;
      first_row   <= '0;
      second_row  <= '0;
      match_count <= '0;
    end else if (cmd.load) begin
      status      <= full ? ST_FULL : ST_OK;
      first_row   <= full ? '0 : OUT_ROW_W'(row_count);
      second_row  <= '0;
      match_count <= found_total;
    end else if (cmd.emit_match) begin
      status      <= ST_MATCH;
      first_row   <= OUT_ROW_W'(scan_first);
      second_row  <= OUT_ROW_W'(pair_second);
      match_count <= found_total_next;
    end else if (cmd.emit_nomore) begin
      status      <= ST_NOMORE;
      first_row   <= '0;
      second_row  <= '0;
      match_count <= found_total;
    end else if (cmd.other) begin
      status      <= ST_OK;
      first_row   <= '0;
      second_row  <= '0;
      match_count <= found_total;
    end
  end

endmodule

/* hw/rtl/fgps_checker.sv */
// Port-level checks of the pair scanner, bound to the top level.
// Depends on fgps_pkg and four_gamete_pair_scan_assert.svh.
`include "four_gamete_pair_scan_assert.svh"

module fgps_checker
  import fgps_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [1:0]           status,
  input logic [OUT_ROW_W-1:0] first_row,
  input logic [OUT_ROW_W-1:0] second_row,
  input logic [TOTAL_W-1:0]   match_count
);

  // A stalled result transaction holds its payload.
  `FGPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable({status, first_row, second_row, match_count}))

  // A reported pair is ordered lower index first.
  `FGPS_ASSERT_NOW(a_pair_order, clk, rst, out_valid && (status == ST_MATCH), first_row < second_row)

  // A match result always carries a nonzero count.
  `FGPS_ASSERT_NOW(a_match_count, clk, rst, out_valid && (status == ST_MATCH), match_count != '0)

  // Full and no-more results carry no row indexes.
  `FGPS_ASSERT_NOW(a_no_index, clk, rst, out_valid && ((status == ST_FULL) || (status == ST_NOMORE)), (first_row == '0) && (second_row == '0))

endmodule

bind four_gamete_pair_scan fgps_checker u_fgps_checker (.*);

/* tb/sv/tb_four_gamete_pair_scan.sv */
// Self-checking testbench for the four-gamete pair scanner.
// Depends on fgps_pkg and four_gamete_pair_scan; drives a directed table, then random sessions,
// and checks each result against a typed table entry or a model of the store and pair cursor.
module tb_four_gamete_pair_scan;
  import fgps_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 16;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 370;
  localparam int MAX_FINDS    = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t                status;
    logic [OUT_ROW_W-1:0]   first;
    logic [OUT_ROW_W-1:0]   second;
    logic [TOTAL_W-1:0]     count;
  } scan_result_t;

  typedef struct packed {
    action_t               act;
    logic [IN_ROW_W-1:0]   bits;
    logic                  typed;
    scan_result_t          want;
  } directed_row_t;

  localparam int N_DIRECTED = 23;

  // Hand-written opening sequence. Rows with typed set carry their result.
  localparam directed_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
    '{ACT_FIND,  24'h000000, 1'b1, '{ST_NOMORE, 12'd0, 12'd0, 23'd0}},
    '{ACT_LOAD,  24'h000000, 1'b1, '{ST_OK,     12'd0, 12'd0, 23'd0}},
    '{ACT_LOAD,  24'hFFFFFF, 1'b1, '{ST_OK,     12'd1, 12'd0, 23'd0}},
    '{ACT_FIND,  24'h000000, 1'b1, '{ST_NOMORE, 12'd0, 12'd0, 23'd0}},
    '{ACT_LOAD,  24'h00FFF0, 1'b1, '{ST_OK,     12'd2, 12'd0, 23'd0}},
    '{ACT_LOAD,  24'hF0F0F0, 1'b1, '{ST_OK,     12'd3, 12'd0, 23'd0}},
    '{ACT_FIND,  24'h000000, 1'b0, '0},
    '{ACT_FIND,  24'h000000, 1'b0, '0},
    '{ACT_NONE,  24'hFFFFFF, 1'b0, '0},
    '{ACT_LOAD,  24'hAAAAAA, 1'b0, '0},
    '{ACT_FIND,  24'h000000, 1'b0, '0},
    '{ACT_CLEAR, 24'h000000, 1'b1, '{ST_OK,     12'd0, 12'd0, 23'd0}},
    '{ACT_LOAD,  24'h555555, 1'b1, '{ST_OK,     12'd0, 12'd0, 23'd0}},
    '{ACT_LOAD,  24'hAAAAAA, 1'b1, '{ST_OK,     12'd1, 12'd0, 23'd0}},
    '{ACT_FIND,  24'h000000, 1'b1, '{ST_NOMORE, 12'd0, 12'd0, 23'd0}},
    '{ACT_LOAD,  24'h800001, 1'b0, '0},
    '{ACT_LOAD,  24'h000001, 1'b0, '0},
    '{ACT_FIND,  24'h000000, 1'b0, '0},
    '{ACT_FIND,  24'h000000, 1'b0, '0},
    '{ACT_FIND,  24'h000000, 1'b0, '0},
    '{ACT_NONE,  24'h000000, 1'b0, '0},
    '{ACT_CLEAR, 24'hFFFFFF, 1'b1, '{ST_OK,     12'd0, 12'd0, 23'd0}},
    '{ACT_FIND,  24'h000000, 1'b1, '{ST_NOMORE, 12'd0, 12'd0, 23'd0}}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           action = ACT_NONE;
  logic [IN_ROW_W-1:0]  row_bits = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           status;
  logic [OUT_ROW_W-1:0] first_row;
  logic [OUT_ROW_W-1:0] second_row;
  logic [TOTAL_W-1:0]   match_count;

  // Model of the row store and the pair cursor.
  logic [ROW_WIDTH-1:0] marker_rows [0:MAX_ROWS-1];
  int unsigned          rows_held   = 0;
  int unsigned          cur_first   = 0;
  int unsigned          cur_second  = 1;
  logic [TOTAL_W-1:0]   match_tally = '0;

  scan_result_t awaited_reports [$];
  status_t      last_status = ST_OK;
  int           items_sent = 0;
  int           mismatches = 0;
  int           snd_idle_pct = 0;
  int           rcv_idle_pct = 0;
  int           hold_requests = 0;
  int           hold_grants = 0;
  int           hold_left = 0;
  int           cycles = 0;

  four_gamete_pair_scan dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .row_bits    (row_bits),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .first_row   (first_row),
    .second_row  (second_row),
    .match_count (match_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Two rows pass the test when all four bit combinations occur somewhere.
  function automatic logic shows_four_gametes(input logic [ROW_WIDTH-1:0] a,
                                              input logic [ROW_WIDTH-1:0] b);
    return |(a & b) && |(a & ~b) && |(~a & b) && |(~a & ~b);
  endfunction

  // Applies one transaction to the model and returns the result it should produce.
  function automatic scan_result_t next_scan_report(input action_t act,
                                                    input logic [IN_ROW_W-1:0] bits);
    scan_result_t rep;
    int unsigned  i;
    int unsigned  j;
    rep = '{ST_OK, '0, '0, match_tally};
    case (act)
      ACT_CLEAR: begin
        rows_held   = 0;
        cur_first   = 0;
        cur_second  = 1;
        match_tally = '0;
        rep.count   = '0;
      end
      ACT_LOAD: begin
        if (rows_held >= MAX_ROWS) begin
          rep.status = ST_FULL;
        end else begin
          marker_rows[rows_held] = bits[ROW_WIDTH-1:0];
          rep.first = OUT_ROW_W'(rows_held);
          rows_held++;
        end
      end
      ACT_FIND: begin
        rep.status = ST_NOMORE;
        while (cur_first + 1 < rows_held) begin
          if (cur_second >= rows_held) begin
            cur_first++;
            cur_second = cur_first + 1;
            continue;
          end
          i = cur_first;
          j = cur_second;
          cur_second++;
          if (shows_four_gametes(marker_rows[i], marker_rows[j])) begin
            if (match_tally < TOTAL_MAX) match_tally++;
            rep = '{ST_MATCH, OUT_ROW_W'(i), OUT_ROW_W'(j), match_tally};
            break;
          end
        end
      end
      default: begin
      end
    endcase
    return rep;
  endfunction

  // Marker rows of mixed density, so that scans both hit and miss.
  function automatic logic [IN_ROW_W-1:0] pick_marker_row();
    logic [IN_ROW_W-1:0] r;
    case ($urandom_range(0, 4))
      0: r = IN_ROW_W'($urandom);
      1: r = IN_ROW_W'($urandom & $urandom & $urandom);
      2: r = ~IN_ROW_W'($urandom & $urandom & $urandom);
      3: r = $urandom_range(0, 1) ? '1 : '0;
      default: r = IN_ROW_W'(1) << $urandom_range(0, IN_ROW_W - 1);
    endcase
    return r;
  endfunction

  // Offers one transaction and, once it is taken, queues the result it should cause.
  task automatic offer_txn(input action_t act, input logic [IN_ROW_W-1:0] bits,
                           input logic typed, input scan_result_t typed_want);
    scan_result_t want;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    row_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = next_scan_report(act, bits);
    last_status = want.status;
    awaited_reports.push_back(typed ? typed_want : want);
    items_sent++;
  endtask

  task automatic offer(input action_t act, input logic [IN_ROW_W-1:0] bits);
    offer_txn(act, bits, 1'b0, '0);
  endtask

  // Holds the sender until every queued result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input scan_result_t want,
                               input scan_result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch (%s): expected st=%0d first=%0d second=%0d count=%0d, got st=%0d first=%0d second=%0d count=%0d",
               what, want.status, want.first, want.second, want.count,
               got.status, got.first, got.second, got.count);
    end
  endtask

  // Result side: checks each taken result and decides the next stall.
  always @(posedge clk) begin : result_side
    scan_result_t got;
    scan_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{status_t'(status), first_row, second_row, match_count};
        if (awaited_reports.size() == 0) begin
          note_mismatch("no result awaited", '0, got);
        end else begin
          want = awaited_reports.pop_front();
          if (got.status != want.status || got.first != want.first ||
              got.second != want.second || got.count != want.count) begin
            note_mismatch("field", want, got);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_stall  <= 1'b1;
      end else if (hold_grants != hold_requests) begin
        hold_grants <= hold_requests;
        hold_left   <= LONG_HOLD;
        out_stall   <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    int start_count;
    int rows_to_load;
    int finds;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (int k = 0; k < N_DIRECTED; k++) begin
      offer_txn(DIRECTED_ROWS[k].act, DIRECTED_ROWS[k].bits,
                DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
    end
    drain_results();

    // Random part in three idling phases.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 38;
          rcv_idle_pct = 45;
        end
        1: begin
          snd_idle_pct = 45;
          rcv_idle_pct = 38;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      // Long receiver hold while the sender keeps offering.
      hold_requests++;

      // Fill the store to capacity once, then push past it.
      if (ph == 2) begin
        offer(ACT_CLEAR, pick_marker_row());
        for (int k = 0; k < MAX_ROWS; k++) offer(ACT_LOAD, IN_ROW_W'($urandom));
        repeat (3) offer(ACT_LOAD, pick_marker_row());
        repeat (3) offer(ACT_FIND, pick_marker_row());
        offer(ACT_CLEAR, pick_marker_row());
        drain_results();
      end

      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          // Well-formed session: clear, load rows, then scan until no more pairs or the find limit.
          offer(ACT_CLEAR, pick_marker_row());
          rows_to_load = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 30)
                                                      : $urandom_range(2, 8);
          repeat (rows_to_load) offer(ACT_LOAD, pick_marker_row());
          finds = 0;
          last_status = ST_OK;
          while (last_status != ST_NOMORE && finds < MAX_FINDS) begin
            case ($urandom_range(0, 19))
              0, 1: offer(ACT_LOAD, pick_marker_row());
              2: offer(ACT_NONE, pick_marker_row());
              default: begin
                offer(ACT_FIND, pick_marker_row());
                finds++;
              end
            endcase
          end
          // A find after the end must leave the cursor in place.
          if ($urandom_range(0, 1)) offer(ACT_FIND, pick_marker_row());
        end else begin
          // Noise: any action with any bits.
          repeat (10) offer(action_t'($urandom_range(0, 3)), IN_ROW_W'($urandom));
        end
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/fgps_pkg.sv
hw/rtl/fgps_ram.sv
hw/rtl/fgps_ctrl.sv
hw/rtl/fgps_dp.sv
hw/rtl/four_gamete_pair_scan.sv
hw/rtl/fgps_checker.sv
tb/sv/tb_four_gamete_pair_scan.sv
